@@ hw/rtl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, controller states and the command and status bundles
// that pass between the controller and the datapath of the exponentiation core.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    // modulus width and operand widths
    localparam int MOD_W  = 31;
    localparam int BASE_W = 32;
    localparam int EXP_W  = 32;

    // step counter covers the base reduction and one modular product
    localparam int MAX_STEPS = (BASE_W > MOD_W) ? BASE_W : MOD_W;
    localparam int CNT_W     = $clog2(MAX_STEPS);

    // stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((BASE_W + EXP_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((MOD_W + 7) / 8) * 8;

    // controller states
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REDUCE = 6'b000010,
        S_NEXT   = 6'b000100,
        S_STEP   = 6'b001000,
        S_COMMIT = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // capture a new item and set up the accumulator
        logic red_step;    // one restoring step of base mod m
        logic prod_start;  // set up both modular products for one exponent bit
        logic prod_step;   // one shift-and-add step of both products
        logic prod_commit; // write products back, shift the exponent
        logic out_load;    // move the result into the output register
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic exp_zero;    // remaining exponent bits are all zero
    } t_dp_status;

endpackage

`default_nettype wire

@@ hw/rtl/modular_exponentiation_core.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base ** exponent mod m by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   write the modulus through i_cfg_we / i_cfg_wdata while the core is idle;
//   it resets to one, which makes every result zero.
//   s_axis carries one item: base and exponent. m_axis returns one item per
//   input: the power modulo m.
// Sequence:
//   the base is first reduced mod m, one restoring step a cycle; then each
//   exponent bit up to the highest set one runs a 31-step shift-and-add
//   loop that forms the multiply and the square together, with setup before
//   it and write-back after it. The next item is taken once the result sits
//   in the output register.
// Reset and stall:
//   reset clears the sequencer and the output valid flag and sets the
//   modulus to one. While the receiver stalls the result stays in the output
//   register; the core still accepts and works one further item and holds it
//   until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_core
    import mexp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [MOD_W-1:0]       i_cfg_wdata,     // modulus
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,    // base_value, exponent_value
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata     // power_result, zero pad
);

    t_dp_cmd          cmd;
    t_dp_status       status;
    logic [MOD_W-1:0] power_result;

    // sequencer
    mexp_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic
    mexp_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_base_value     (s_axis_tdata[BASE_W-1:0]),
        .i_exponent_value (s_axis_tdata[BASE_W+EXP_W-1:BASE_W]),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_power_result   (power_result)
    );

    assign m_axis_tdata = OUT_TDATA_W'(power_result);

endmodule

`default_nettype wire

@@ hw/rtl/mexp_datapath.sv @@
// ----------------------------------------------------------------------------
// mexp_datapath
// Modulus register, base reduction, and two shift-and-add modular
// multipliers sharing one doubling addend (multiply and square in parallel).
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_datapath
    import mexp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [MOD_W-1:0]  i_cfg_wdata,
    input  wire logic [BASE_W-1:0] i_base_value,
    input  wire logic [EXP_W-1:0]  i_exponent_value,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    output logic [MOD_W-1:0]       o_power_result
);

    logic [MOD_W-1:0]  r_mod;
    logic [BASE_W-1:0] r_base, n_base;
    logic [EXP_W-1:0]  r_exp, n_exp;
    logic [MOD_W-1:0]  r_acc, n_acc;
    logic [MOD_W-1:0]  r_sq, n_sq;
    logic [MOD_W-1:0]  r_add, n_add;
    logic [MOD_W-1:0]  r_xm, n_xm;
    logic [MOD_W-1:0]  r_xs, n_xs;
    logic [MOD_W-1:0]  r_pm, n_pm;
    logic [MOD_W-1:0]  r_ps, n_ps;
    logic [MOD_W-1:0]  r_res, n_res;

    logic [MOD_W:0]    mod_ext;
    logic [MOD_W:0]    red_t;
    logic [MOD_W:0]    sum_m;
    logic [MOD_W:0]    sum_s;
    logic [MOD_W:0]    dbl;
    logic [MOD_W-1:0]  red_r;
    logic [MOD_W-1:0]  sum_m_r;
    logic [MOD_W-1:0]  sum_s_r;
    logic [MOD_W-1:0]  dbl_r;

    // modulus register, reset to one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_W'(1);
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_wdata;
        end
    end

    // restoring step, two adds and a doubling, each with one conditional subtract
    always_comb begin
        mod_ext = {1'b0, r_mod};
        red_t   = {r_sq, r_base[BASE_W-1]};
        red_r   = (red_t >= mod_ext) ? MOD_W'(red_t - mod_ext) : red_t[MOD_W-1:0];
        sum_m   = {1'b0, r_pm} + {1'b0, r_add};
        sum_m_r = (sum_m >= mod_ext) ? MOD_W'(sum_m - mod_ext) : sum_m[MOD_W-1:0];
        sum_s   = {1'b0, r_ps} + {1'b0, r_add};
        sum_s_r = (sum_s >= mod_ext) ? MOD_W'(sum_s - mod_ext) : sum_s[MOD_W-1:0];
        dbl     = {r_add, 1'b0};
        dbl_r   = (dbl >= mod_ext) ? MOD_W'(dbl - mod_ext) : dbl[MOD_W-1:0];
    end

    // next-state selection by command
    always_comb begin
        n_base = r_base;
        n_exp  = r_exp;
        n_acc  = r_acc;
        n_sq   = r_sq;
        n_add  = r_add;
        n_xm   = r_xm;
        n_xs   = r_xs;
        n_pm   = r_pm;
        n_ps   = r_ps;
        n_res  = r_res;
        if (i_cmd.load) begin
            n_base = i_base_value;
            n_exp  = i_exponent_value;
            n_sq   = '0;
            n_acc  = (r_mod == MOD_W'(1)) ? '0 : MOD_W'(1);
        end
        if (i_cmd.red_step) begin
            n_sq   = red_r;
            n_base = {r_base[BASE_W-2:0], 1'b0};
        end
        if (i_cmd.prod_start) begin
            n_add = r_sq;
            n_xm  = r_acc;
            n_xs  = r_sq;
            n_pm  = '0;
            n_ps  = '0;
        end
        if (i_cmd.prod_step) begin
            if (r_xm[0]) begin
                n_pm = sum_m_r;
            end
            if (r_xs[0]) begin
                n_ps = sum_s_r;
            end
            n_add = dbl_r;
            n_xm  = {1'b0, r_xm[MOD_W-1:1]};
            n_xs  = {1'b0, r_xs[MOD_W-1:1]};
        end
        if (i_cmd.prod_commit) begin
            if (r_exp[0]) begin
                n_acc = r_pm;
            end
            n_sq  = r_ps;
            n_exp = {1'b0, r_exp[EXP_W-1:1]};
        end
        if (i_cmd.out_load) begin
            // a zero modulus gives zero
            n_res = (r_mod == '0) ? '0 : r_acc;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_exp  <= n_exp;
        r_acc  <= n_acc;
        r_sq   <= n_sq;
        r_add  <= n_add;
        r_xm   <= n_xm;
        r_xs   <= n_xs;
        r_pm   <= n_pm;
        r_ps   <= n_ps;
        r_res  <= n_res;
    end

    assign o_status.exp_zero = (r_exp == '0);
    assign o_power_result    = r_res;

endmodule

`default_nettype wire

@@ hw/rtl/mexp_controller.sv @@
// ----------------------------------------------------------------------------
// mexp_controller
// Sequencer for base reduction and the square-and-multiply loop, plus the
// input ready and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_controller
    import mexp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;
    logic             in_fire;
    logic             slot_free;

    assign in_fire   = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_valid || i_out_ready;

    // state transitions and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.red_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(BASE_W - 1)) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_status.exp_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.prod_start = 1'b1;
                    n_cnt            = '0;
                    n_state          = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.prod_step = 1'b1;
                n_cnt           = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MOD_W - 1)) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.prod_commit = 1'b1;
                n_state           = S_NEXT;
            end
            S_FINISH: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the item is taken
    always_comb begin
        n_valid = r_valid;
        if (o_cmd.out_load) begin
            n_valid = 1'b1;
        end else if (r_valid && i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_valid;

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_valid || i_out_ready))
        else $error("result overwritten while still held");

    // product steps never run past the operand width
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_cnt <= CNT_W'(MOD_W - 1)))
        else $error("product step counter out of range");

    // a commit always follows the last product step
    a_commit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> ($past(r_state) == S_STEP))
        else $error("commit without preceding product step");

endmodule

`default_nettype wire
